### src/ols_pkg.sv
package ols_pkg;

  // Default sizing of the list
  localparam int DEPTH_DEF  = 16;
  localparam int DATA_W_DEF = 32;

  // Port field widths
  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 2;
  localparam int LENGTH_W = 5;
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 40;

  // Command codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_APPEND    = 3'd0,
    ACT_PREPEND   = 3'd1,
    ACT_READ      = 3'd2,
    ACT_REMOVE    = 3'd3,
    ACT_POP_FRONT = 3'd4,
    ACT_POP_BACK  = 3'd5
  } action_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  // Operation applied to every cell of the chain
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_APPEND,
    OP_PREPEND,
    OP_REMOVE,
    OP_POP_FRONT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     capture;
  } cell_cmd_t;

endpackage

### src/ols_cell.sv
module ols_cell
  import ols_pkg::*;
#(
  parameter int DATA_W = DATA_W_DEF,
  parameter int DEPTH  = DEPTH_DEF,
  parameter int INDEX  = 0
) (
  input  logic                         clk,
  input  cell_cmd_t                    cmd,
  input  logic [$clog2(DEPTH+1)-1:0]   count,
  input  logic [$clog2(DEPTH)-1:0]     read_idx,
  input  logic [DATA_W-1:0]            word,
  input  logic [DATA_W-1:0]            left_data,
  input  logic [DATA_W-1:0]            right_data,
  input  logic                         prefix_in,
  output logic                         prefix_out,
  output logic [DATA_W-1:0]            data,
  output logic [DATA_W-1:0]            rd_data
);

  localparam int CNT_W = $clog2(DEPTH+1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [CNT_W-1:0] MY_POS = CNT_W'(INDEX);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic match_q;
  logic valid;

  // Slot is live while it sits below the entry count
  assign valid      = MY_POS < count;
  // Pass on whether a live match lies at or in front of this slot
  assign prefix_out = prefix_in | (valid & match_q);
  // Drive own word onto the read bus when addressed
  assign rd_data    = (MY_IDX == read_idx) ? data : '0;

  // Latch compare result, then move data as the command asks
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      match_q <= (data == word);
    end
    case (cmd.op)
      OP_APPEND: begin
        if (MY_POS == count) begin
          data <= word;
        end
      end
      OP_PREPEND:   data <= left_data;
      OP_REMOVE: begin
        if (prefix_out) begin
          data <= right_data;
        end
      end
      OP_POP_FRONT: data <= right_data;
      default:      data <= data;
    endcase
  end

endmodule

### src/ordered_list_store_core.sv
// Sequence: idle takes one command at a time, execute registers its result word; a remove
//   first passes a match state, in which every cell latches its compare before the priority
//   chain along the cells decides which slots close the gap. No new command is taken until
//   the last one has executed.
// A stalled result holds the block in its execute cycle until the word is taken.
// Reset (rst, synchronous): clears entry count, sequencer and result valid; cell data is
//   left as it is and needs no clearing pass.
module ordered_list_store_core
  import ols_pkg::*;
#(
  parameter int DEPTH  = DEPTH_DEF,
  parameter int DATA_W = DATA_W_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // entry_value[31:0], position[35:32], zero fill
  input  logic [ACTION_W-1:0] s_tuser,   // action[2:0]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata    // result_value[31:0], status[33:32],
                                         // length[38:34], is_empty[39]
);

  localparam int CNT_W = $clog2(DEPTH+1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int AW    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_EXEC
  } state_t;

  state_t                state;
  logic [ACTION_W-1:0]   cmd_action;
  logic [VALUE_W-1:0]    cmd_value;
  logic [POS_W-1:0]      cmd_pos;
  logic [CNT_W-1:0]      count;

  logic [CNT_W-1:0]      count_next;
  logic [VALUE_W-1:0]    value_next;
  status_t               status_next;
  cell_cmd_t             cell_cmd;
  cell_op_t              op_next;
  logic                  out_free;
  logic                  fire;
  logic                  full;
  logic                  empty;
  logic                  read_hit;
  logic [AW-1:0]         addr_w;
  logic [IDX_W-1:0]      read_idx;
  logic [DATA_W-1:0]     word;
  logic [DATA_W-1:0]     rd_or;

  logic [DATA_W-1:0]     cell_data [DEPTH];
  logic [DATA_W-1:0]     cell_rd   [DEPTH];
  logic [DEPTH:0]        prefix;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign fire     = (state == S_EXEC) && out_free;
  assign word     = DATA_W'(cmd_value);
  assign full     = (count == FULL_CNT);
  assign empty    = (count == '0);

  // Pick the read slot: back for pop back, front for pop front, else position
  always_comb begin
    case (action_t'(cmd_action))
      ACT_POP_BACK:  addr_w = AW'(count - CNT_W'(1));
      ACT_POP_FRONT: addr_w = '0;
      default:       addr_w = AW'(cmd_pos);
    endcase
  end
  assign read_idx = addr_w[IDX_W-1:0];
  assign read_hit = AW'(cmd_pos) < AW'(count);

  // Collect the addressed word from the cells
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  // Work out the result and the list change for the held command
  always_comb begin
    count_next  = count;
    value_next  = '0;
    status_next = STAT_OK;
    op_next     = OP_HOLD;
    case (action_t'(cmd_action))
      ACT_APPEND: begin
        if (full) begin
          status_next = STAT_FULL;
        end else begin
          op_next    = OP_APPEND;
          count_next = count + CNT_W'(1);
        end
      end
      ACT_PREPEND: begin
        if (full) begin
          status_next = STAT_FULL;
        end else begin
          op_next    = OP_PREPEND;
          count_next = count + CNT_W'(1);
        end
      end
      ACT_READ: begin
        if (read_hit) begin
          value_next = VALUE_W'(rd_or);
        end else begin
          status_next = STAT_NOT_FOUND;
        end
      end
      ACT_REMOVE: begin
        op_next = OP_REMOVE;
        if (prefix[DEPTH]) begin
          count_next = count - CNT_W'(1);
        end else begin
          status_next = STAT_NOT_FOUND;
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          status_next = STAT_EMPTY;
        end else begin
          op_next    = OP_POP_FRONT;
          value_next = VALUE_W'(rd_or);
          count_next = count - CNT_W'(1);
        end
      end
      ACT_POP_BACK: begin
        if (empty) begin
          status_next = STAT_EMPTY;
        end else begin
          value_next = VALUE_W'(rd_or);
          count_next = count - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Broadcast the cell operation only in the cycle the result word is registered
  always_comb begin
    cell_cmd.capture = (state == S_MATCH);
    cell_cmd.op      = fire ? op_next : OP_HOLD;
  end

  // Build the chain of cells, front at index 0
  assign prefix[0] = 1'b0;
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] left_d;
    logic [DATA_W-1:0] right_d;
    if (g == 0) begin : g_front
      assign left_d = word;
    end else begin : g_inner_l
      assign left_d = cell_data[g-1];
    end
    if (g == DEPTH-1) begin : g_back
      assign right_d = '0;
    end else begin : g_inner_r
      assign right_d = cell_data[g+1];
    end
    ols_cell #(
      .DATA_W (DATA_W),
      .DEPTH  (DEPTH),
      .INDEX  (g)
    ) u_cell (
      .clk        (clk),
      .cmd        (cell_cmd),
      .count      (count),
      .read_idx   (read_idx),
      .word       (word),
      .left_data  (left_d),
      .right_data (right_d),
      .prefix_in  (prefix[g]),
      .prefix_out (prefix[g+1]),
      .data       (cell_data[g]),
      .rd_data    (cell_rd[g])
    );
  end

  // Sequencer, entry count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // Raise the result word on execute, drop it once taken
      if (fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd_action <= s_tuser;
            cmd_value  <= s_tdata[VALUE_W-1:0];
            cmd_pos    <= s_tdata[VALUE_W+POS_W-1:VALUE_W];
            state      <= (action_t'(s_tuser) == ACT_REMOVE) ? S_MATCH : S_EXEC;
          end
        end
        S_MATCH: state <= S_EXEC;
        S_EXEC: begin
          if (out_free) begin
            count    <= count_next;
            m_tdata  <= {(count_next == '0), LENGTH_W'(count_next), status_next,
                         value_next};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### src/ols_checker.sv
module ols_checker
  import ols_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic [S_DATA_W-1:0] s_tdata,
  input logic [ACTION_W-1:0] s_tuser,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata
);

  // A waiting result word keeps its contents
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // Reset leaves no result pending
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // An empty status comes with an empty list and no data
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[33:32] == STAT_EMPTY) |->
      m_tdata[39] && (m_tdata[31:0] == '0))
    else $error("empty status with data or entries");

  // Not found never carries data
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[33:32] == STAT_NOT_FOUND) |-> (m_tdata[31:0] == '0))
    else $error("not found status with data");

  // A refused push never comes with an empty list
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[33:32] == STAT_FULL) |-> !m_tdata[39])
    else $error("full status on an empty list");

endmodule

bind ordered_list_store_core ols_checker u_ols_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### sim/ordered_list_store_core_test.sv
`timescale 1ns / 100ps

module ordered_list_store_core_test;
  import ols_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEF;
  localparam int FILL_W     = S_DATA_W - VALUE_W - POS_W;

  // Codes with no command behind them: the list must stay untouched
  localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

  localparam int RANDOM_CMDS      = 1000;
  localparam int LONG_HOLD_AT     = 400;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_AT         = 600;
  localparam int TAIL_CYCLES      = 20;
  localparam int MAX_REPORTS      = 10;

  typedef struct {
    logic [ACTION_W-1:0] action;
    logic [VALUE_W-1:0]  value;
    logic [POS_W-1:0]    pos;
    int                  gap;
    bit                  drain;
  } list_cmd_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    status_t             status;
    logic [LENGTH_W-1:0] length;
    logic                is_empty;
  } list_result_t;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata  = '0;
  logic [ACTION_W-1:0] s_tuser  = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  list_cmd_t          cmd_queue[$];
  list_result_t       expected_results[$];
  logic [VALUE_W-1:0] list_model[$];
  logic [VALUE_W-1:0] value_pool[8];

  int cmds_taken     = 0;
  int results_taken  = 0;
  int mismatches     = 0;
  int gap_left       = 0;
  int stall_left     = 0;
  bit long_hold_done = 1'b0;

  ordered_list_store_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  function automatic void add_cmd(logic [ACTION_W-1:0] action, logic [VALUE_W-1:0] value,
                                  logic [POS_W-1:0] pos);
    list_cmd_t c;
    c.action = action;
    c.value  = value;
    c.pos    = pos;
    // every fourth stretch of commands goes back to back
    c.gap    = ((cmd_queue.size() / 80) % 4 == 3) ? 0 : pick_gap();
    c.drain  = 1'b0;
    cmd_queue.push_back(c);
  endfunction

  // Apply one command to the list copy and work out its result word
  function automatic list_result_t apply_list_cmd(list_cmd_t c);
    list_result_t r;
    int hit;
    r.value  = '0;
    r.status = STAT_OK;
    hit      = -1;
    case (c.action)
      ACT_APPEND: begin
        if (list_model.size() >= LIST_DEPTH) r.status = STAT_FULL;
        else list_model.push_back(c.value);
      end
      ACT_PREPEND: begin
        if (list_model.size() >= LIST_DEPTH) r.status = STAT_FULL;
        else list_model.push_front(c.value);
      end
      ACT_READ: begin
        if (c.pos < list_model.size()) r.value = list_model[c.pos];
        else r.status = STAT_NOT_FOUND;
      end
      ACT_REMOVE: begin
        // only the first match from the front goes
        foreach (list_model[i])
          if (hit < 0 && list_model[i] == c.value) hit = i;
        if (hit < 0) r.status = STAT_NOT_FOUND;
        else list_model.delete(hit);
      end
      ACT_POP_FRONT: begin
        if (list_model.size() == 0) r.status = STAT_EMPTY;
        else r.value = list_model.pop_front();
      end
      ACT_POP_BACK: begin
        if (list_model.size() == 0) r.status = STAT_EMPTY;
        else r.value = list_model.pop_back();
      end
      default: ;
    endcase
    r.length   = LENGTH_W'(list_model.size());
    r.is_empty = (list_model.size() == 0);
    return r;
  endfunction

  // Drive the command words, each after its gap
  always @(posedge clk) begin
    int hold;
    bit offer;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= '0;
      gap_left <= 0;
    end else if (!s_tvalid || s_tready) begin
      offer = 1'b0;
      if (s_tvalid) begin
        void'(cmd_queue.pop_front());
        hold = (cmd_queue.size() > 0) ? cmd_queue[0].gap : 0;
      end else begin
        hold = gap_left;
      end
      if (hold > 0) begin
        gap_left <= hold - 1;
      end else if (cmd_queue.size() > 0 &&
                   !(cmd_queue[0].drain && (s_tvalid || results_taken != cmds_taken))) begin
        offer   = 1'b1;
        s_tdata <= {{FILL_W{1'b0}}, cmd_queue[0].pos, cmd_queue[0].value};
        s_tuser <= cmd_queue[0].action;
      end
      s_tvalid <= offer;
    end
  end

  // Stall the result side; hold off once for a long stretch
  always @(posedge clk) begin
    if (rst) begin
      m_tready       <= 1'b0;
      stall_left     <= 0;
      long_hold_done <= 1'b0;
    end else if (!long_hold_done && results_taken >= LONG_HOLD_AT) begin
      long_hold_done <= 1'b1;
      stall_left     <= LONG_HOLD_CYCLES;
      m_tready       <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (((m_tvalid && m_tready) || $urandom_range(0, 9) == 0) &&
          (results_taken / 120) % 4 != 2)
        stall_left <= pick_gap();
    end
  end

  // Predict on each accepted command, check each accepted result
  always @(posedge clk) begin
    list_result_t want, got;
    list_cmd_t taken;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_taken <= results_taken + 1;
        got.value    = m_tdata[VALUE_W-1:0];
        got.status   = status_t'(m_tdata[VALUE_W +: STATUS_W]);
        got.length   = m_tdata[VALUE_W + STATUS_W +: LENGTH_W];
        got.is_empty = m_tdata[VALUE_W + STATUS_W + LENGTH_W];
        if (expected_results.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: result word with nothing expected: value %h status %0d len %0d",
                     $realtime, got.value, got.status, got.length);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (got.value !== want.value || got.status !== want.status ||
              got.length !== want.length || got.is_empty !== want.is_empty) begin
            if (mismatches < MAX_REPORTS)
              $display("%0t: mismatch: exp %h/%0d/%0d/%0b got %h/%0d/%0d/%0b",
                       $realtime, want.value, want.status, want.length, want.is_empty,
                       got.value, got.status, got.length, got.is_empty);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        cmds_taken <= cmds_taken + 1;
        taken.action = s_tuser;
        taken.value  = s_tdata[VALUE_W-1:0];
        taken.pos    = s_tdata[VALUE_W +: POS_W];
        taken.gap    = 0;
        taken.drain  = 1'b0;
        expected_results.push_back(apply_list_cmd(taken));
      end
    end
  end

  // Build the stimulus, release reset, wait for the list to drain
  initial begin
    int r;
    bit grow;
    logic [ACTION_W-1:0] act;
    logic [VALUE_W-1:0]  val;
    logic [POS_W-1:0]    pos;

    value_pool[0] = '0;
    value_pool[1] = '1;
    for (int k = 2; k < 8; k++) value_pool[k] = $urandom;

    // empty list: pops, read and remove find nothing
    add_cmd(ACT_POP_FRONT, 32'h0, 4'd0);
    add_cmd(ACT_POP_BACK, 32'h0, 4'd0);
    add_cmd(ACT_READ, 32'h0, 4'd0);
    add_cmd(ACT_REMOVE, 32'h0, 4'd0);
    // fill to the top from both ends, with repeated values
    for (int k = 0; k < LIST_DEPTH; k++)
      add_cmd(k[0] ? ACT_PREPEND : ACT_APPEND, value_pool[k % 8], 4'(k));
    // full list refuses both pushes
    add_cmd(ACT_APPEND, 32'hDEAD_BEEF, 4'd0);
    add_cmd(ACT_PREPEND, 32'hDEAD_BEEF, 4'd0);
    add_cmd(ACT_READ, 32'h0, 4'd15);
    add_cmd(ACT_READ, 32'hFFFF_FFFF, 4'd0);
    add_cmd(ACT_REMOVE, value_pool[2], 4'd0);
    add_cmd(ACT_REMOVE, 32'h0BAD_F00D, 4'd0);
    add_cmd(ACT_POP_FRONT, 32'h0, 4'd0);
    add_cmd(ACT_POP_BACK, 32'h0, 4'd0);
    add_cmd(ACT_SPARE_6, 32'h1234_5678, 4'd3);
    add_cmd(ACT_SPARE_7, 32'hFFFF_FFFF, 4'd15);

    // random part: alternate push-heavy and pop-heavy stretches
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      grow = ((n / 50) % 2 == 0);
      r    = $urandom_range(0, 99);
      if (grow) begin
        if (r < 30) act = ACT_APPEND;
        else if (r < 55) act = ACT_PREPEND;
        else if (r < 70) act = ACT_READ;
        else if (r < 82) act = ACT_REMOVE;
        else if (r < 91) act = ACT_POP_FRONT;
        else if (r < 98) act = ACT_POP_BACK;
        else act = $urandom_range(0, 1) ? ACT_SPARE_7 : ACT_SPARE_6;
      end else begin
        if (r < 10) act = ACT_APPEND;
        else if (r < 20) act = ACT_PREPEND;
        else if (r < 38) act = ACT_READ;
        else if (r < 58) act = ACT_REMOVE;
        else if (r < 78) act = ACT_POP_FRONT;
        else if (r < 98) act = ACT_POP_BACK;
        else act = $urandom_range(0, 1) ? ACT_SPARE_7 : ACT_SPARE_6;
      end
      val = ($urandom_range(0, 9) < 6) ? value_pool[$urandom_range(0, 7)] : $urandom;
      pos = $urandom_range(0, 1) ? POS_W'($urandom_range(0, 3)) :
                                   POS_W'($urandom_range(0, 15));
      add_cmd(act, val, pos);
      if (n == DRAIN_AT) cmd_queue[cmd_queue.size() - 1].drain = 1'b1;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (cmd_queue.size() > 0) @(posedge clk);
    @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
